>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the complex matrix unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CMA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when pre holds, post holds in the cycle after.
`define CMA_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> src/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Types, codes and small helper functions of the complex matrix unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cma_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned ELEMS     = 9;
  localparam int unsigned ADDR_W    = 4;

  localparam logic [ADDR_W-1:0] ELEM_LAST       = 4'd8;
  localparam logic [3:0]        STEP_LAST_MUL   = 4'd11;
  localparam logic [3:0]        STEP_LAST_ELEM  = 4'd3;
  localparam logic [3:0]        STEP_LAST_TRACE = 4'd5;

  typedef enum logic [2:0] {
    FUNC_MUL   = 3'd0,
    FUNC_ADD   = 3'd1,
    FUNC_SUB   = 3'd2,
    FUNC_SCALE = 3'd3,
    FUNC_TRACE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    SRC_ARBR = 3'd0,
    SRC_AIBI = 3'd1,
    SRC_ARBI = 3'd2,
    SRC_AIBR = 3'd3,
    SRC_AR   = 3'd4,
    SRC_AI   = 3'd5,
    SRC_BR   = 3'd6,
    SRC_BI   = 3'd7
  } src_e;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_ISSUE = 2'd2
  } state_e;

  typedef struct packed {
    logic       vld;
    src_e       src;
    logic       neg;
    logic       first;
    logic       fin;
    logic       shift;
    logic [1:0] row;
    logic [1:0] col;
    logic       last;
  } mop_t;

  function automatic logic [3:0] elem_pos(logic [ADDR_W-1:0] k);
    logic [3:0] rc;
    case (k)
      4'd0:    rc = {2'd0, 2'd0};
      4'd1:    rc = {2'd0, 2'd1};
      4'd2:    rc = {2'd0, 2'd2};
      4'd3:    rc = {2'd1, 2'd0};
      4'd4:    rc = {2'd1, 2'd1};
      4'd5:    rc = {2'd1, 2'd2};
      4'd6:    rc = {2'd2, 2'd0};
      4'd7:    rc = {2'd2, 2'd1};
      4'd8:    rc = {2'd2, 2'd2};
      default: rc = {2'd0, 2'd0};
    endcase
    return rc;
  endfunction

endpackage

>>> src/complex_matrix_arith_3x3.sv
// ----------------------------------------------------------------------------
// complex_matrix_arith_3x3
// A 3x3 complex matrix unit in signed fixed point (Q16.16 by default). Nine
// input items load the A and B element pairs in row-major order, one item
// per cycle. The func of the ninth item selects multiply, add, subtract,
// scale of B by the first A element, or trace of A, and the unit then
// returns nine row-major results (one for trace), the final one marked by
// last. All work runs through one shared signed multiplier and complex
// accumulator fed from two small element RAMs. Each result of the matrix
// product takes twelve multiplier passes. Input items are not accepted
// while an operation runs; a reserved func drops the loaded matrices
// without a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_matrix_arith_3x3 import cma_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                func_i,
  input  logic signed [FIELD_W-1:0] a_re_i,
  input  logic signed [FIELD_W-1:0] a_im_i,
  input  logic signed [FIELD_W-1:0] b_re_i,
  input  logic signed [FIELD_W-1:0] b_im_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                row_o,
  output logic [1:0]                col_o,
  output logic signed [FIELD_W-1:0] out_re_o,
  output logic signed [FIELD_W-1:0] out_im_o,
  output logic                      saturated_o,
  output logic                      last_o
);

  logic                    wr_en, busy;
  logic [ADDR_W-1:0]       wr_addr, a_raddr, b_raddr;
  logic [2*DATA_WIDTH-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
  mop_t                    mop;

  assign a_wdata = {a_im_i[DATA_WIDTH-1:0], a_re_i[DATA_WIDTH-1:0]};
  assign b_wdata = {b_im_i[DATA_WIDTH-1:0], b_re_i[DATA_WIDTH-1:0]};

  cma_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .busy_i     (busy),
    .in_ready_o (in_ready_o),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .a_raddr_o  (a_raddr),
    .b_raddr_o  (b_raddr),
    .mop_o      (mop)
  );

  cma_ram #(
    .WIDTH (2 * DATA_WIDTH),
    .DEPTH (ELEMS)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  cma_ram #(
    .WIDTH (2 * DATA_WIDTH),
    .DEPTH (ELEMS)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  cma_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mop_i       (mop),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .out_ready_i (out_ready_i),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .row_o       (row_o),
    .col_o       (col_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .saturated_o (saturated_o),
    .last_o      (last_o)
  );

endmodule

>>> src/cma_ram.sv
// ----------------------------------------------------------------------------
// cma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cma_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cma_seq.sv
// ----------------------------------------------------------------------------
// cma_seq
// Sequencer: counts loaded elements and issues the micro-operations of each
// result to the shared datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cma_seq import cma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        func_i,
  input  logic              busy_i,
  output logic              in_ready_o,
  output logic              wr_en_o,
  output logic [ADDR_W-1:0] wr_addr_o,
  output logic [ADDR_W-1:0] a_raddr_o,
  output logic [ADDR_W-1:0] b_raddr_o,
  output mop_t              mop_o
);

  state_e            state_q, state_d;
  func_e             func_q, func_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] res_q, res_d;
  logic [3:0]        step_q, step_d;

  logic [1:0]        row, col, j, p;
  logic [3:0]        step_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      func_q  <= FUNC_MUL;
      cnt_q   <= '0;
      res_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
      cnt_q   <= cnt_d;
      res_q   <= res_d;
      step_q  <= step_d;
    end
  end

  assign {row, col} = elem_pos(res_q);
  assign j = step_q[3:2];
  assign p = step_q[1:0];

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    cnt_d      = cnt_q;
    res_d      = res_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    wr_en_o    = 1'b0;
    wr_addr_o  = cnt_q;
    a_raddr_o  = res_q;
    b_raddr_o  = res_q;
    step_last  = STEP_LAST_ELEM;
    mop_o      = '0;
    mop_o.src  = src_e'({1'b0, p});
    mop_o.row  = row;
    mop_o.col  = col;

    case (func_q)
      FUNC_MUL: begin
        a_raddr_o   = ADDR_W'({row, 1'b0}) + ADDR_W'(row) + ADDR_W'(j);
        b_raddr_o   = ADDR_W'({j, 1'b0}) + ADDR_W'(j) + ADDR_W'(col);
        mop_o.neg   = (p == 2'd1);
        mop_o.shift = 1'b1;
        step_last   = STEP_LAST_MUL;
      end
      FUNC_SCALE: begin
        a_raddr_o   = '0;
        mop_o.neg   = (p == 2'd1);
        mop_o.shift = 1'b1;
      end
      FUNC_ADD, FUNC_SUB: begin
        mop_o.src = src_e'({1'b1, p});
        mop_o.neg = (func_q == FUNC_SUB) && p[1];
      end
      FUNC_TRACE: begin
        a_raddr_o = ADDR_W'({step_q[2:1], 2'b00});
        mop_o.src = step_q[0] ? SRC_AI : SRC_AR;
        step_last = STEP_LAST_TRACE;
      end
      default: begin
        step_last = '0;
      end
    endcase

    mop_o.first = (step_q == '0);
    mop_o.fin   = (step_q == step_last);
    mop_o.last  = (func_q == FUNC_TRACE) || (res_q == ELEM_LAST);

    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        wr_en_o    = in_valid_i;
        if (in_valid_i) begin
          if (cnt_q == ELEM_LAST) begin
            cnt_d  = '0;
            res_d  = '0;
            func_d = func_e'(func_i);
            if (func_i inside {FUNC_MUL, FUNC_ADD, FUNC_SUB, FUNC_SCALE, FUNC_TRACE}) begin
              state_d = ST_WAIT;
            end
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (!busy_i) begin
          state_d = ST_ISSUE;
          step_d  = '0;
        end
      end
      ST_ISSUE: begin
        mop_o.vld = 1'b1;
        step_d    = step_q + 1'b1;
        if (mop_o.fin) begin
          if (mop_o.last) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_WAIT;
            res_d   = res_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  `CMA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= ELEM_LAST, "element counter out of range")
  `CMA_ASSERT(a_res_range, clk_i, rst_ni, res_q <= ELEM_LAST, "result index out of range")
  `CMA_ASSERT_NEXT(a_done_ready, clk_i, rst_ni, mop_o.vld && mop_o.fin && mop_o.last,
                   in_ready_o, "not ready after the final result was issued")

endmodule

>>> src/cma_dp.sv
// ----------------------------------------------------------------------------
// cma_dp
// Shared datapath: one signed multiplier, a complex accumulator, the
// fixed-point shift with saturation and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cma_dp import cma_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mop_t                      mop_i,
  input  logic [2*DATA_WIDTH-1:0]   a_rdata_i,
  input  logic [2*DATA_WIDTH-1:0]   b_rdata_i,
  input  logic                      out_ready_i,
  output logic                      busy_o,
  output logic                      out_valid_o,
  output logic [1:0]                row_o,
  output logic [1:0]                col_o,
  output logic signed [FIELD_W-1:0] out_re_o,
  output logic signed [FIELD_W-1:0] out_im_o,
  output logic                      saturated_o,
  output logic                      last_o
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned PW    = 2 * DATA_WIDTH;
  localparam int unsigned ACC_W = 2 * DATA_WIDTH + 4;
  localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW:0] sat_fn(logic signed [ACC_W-1:0] v, logic sh);
    logic signed [ACC_W-1:0] s;
    logic [ACC_W-DW:0]       top;
    s   = sh ? (v >>> FRAC_BITS) : v;
    top = s[ACC_W-1:DW-1];
    if ((&top) || !(|top)) begin
      return {1'b0, s[DW-1:0]};
    end else if (s[ACC_W-1]) begin
      return {1'b1, MIN_V};
    end else begin
      return {1'b1, MAX_V};
    end
  endfunction

  mop_t mop1_q, mop2_q, mop3_q;

  logic signed [DW-1:0]    ar, ai, br, bi;
  logic signed [DW-1:0]    mx, my, opnd;
  logic signed [PW-1:0]    prod;
  logic                    is_prod;
  logic signed [PW-1:0]    term_q, term_d;

  logic signed [ACC_W-1:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d, t_ext;
  logic                    dest_im;

  logic [DW:0]             sat_re, sat_im;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              row_q, col_q;
  logic signed [FIELD_W-1:0] out_re_q, out_im_q;
  logic                    sat_q, last_q;

  assign ar = a_rdata_i[DW-1:0];
  assign ai = a_rdata_i[PW-1:DW];
  assign br = b_rdata_i[DW-1:0];
  assign bi = b_rdata_i[PW-1:DW];

  always_comb begin
    mx      = ar;
    my      = br;
    opnd    = ar;
    is_prod = 1'b1;
    case (mop1_q.src)
      SRC_ARBR: begin mx = ar; my = br; end
      SRC_AIBI: begin mx = ai; my = bi; end
      SRC_ARBI: begin mx = ar; my = bi; end
      SRC_AIBR: begin mx = ai; my = br; end
      SRC_AR:   begin opnd = ar; is_prod = 1'b0; end
      SRC_AI:   begin opnd = ai; is_prod = 1'b0; end
      SRC_BR:   begin opnd = br; is_prod = 1'b0; end
      SRC_BI:   begin opnd = bi; is_prod = 1'b0; end
      default:  begin is_prod = 1'b1; end
    endcase
    prod   = mx * my;
    term_d = is_prod ? prod : PW'(opnd);
  end

  always_comb begin
    dest_im  = mop2_q.src inside {SRC_ARBI, SRC_AIBR, SRC_AI, SRC_BI};
    t_ext    = ACC_W'(term_q);
    if (mop2_q.neg) begin
      t_ext = -t_ext;
    end
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (mop2_q.vld) begin
      acc_re_d = (mop2_q.first ? '0 : acc_re_q) + (dest_im ? '0 : t_ext);
      acc_im_d = (mop2_q.first ? '0 : acc_im_q) + (dest_im ? t_ext : '0);
    end
  end

  assign sat_re = sat_fn(acc_re_q, mop3_q.shift);
  assign sat_im = sat_fn(acc_im_q, mop3_q.shift);

  always_comb begin
    out_valid_d = out_valid_q;
    if (mop3_q.vld && mop3_q.fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mop1_q      <= '0;
      mop2_q      <= '0;
      mop3_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mop1_q      <= mop_i;
      mop2_q      <= mop1_q;
      mop3_q      <= mop2_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q   <= term_d;
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    if (mop3_q.vld && mop3_q.fin) begin
      row_q    <= mop3_q.row;
      col_q    <= mop3_q.col;
      last_q   <= mop3_q.last;
      sat_q    <= sat_re[DW] | sat_im[DW];
      out_re_q <= FIELD_W'($signed(sat_re[DW-1:0]));
      out_im_q <= FIELD_W'($signed(sat_im[DW-1:0]));
    end
  end

  assign busy_o      = mop1_q.vld | mop2_q.vld | mop3_q.vld | out_valid_q;
  assign out_valid_o = out_valid_q;
  assign row_o       = row_q;
  assign col_o       = col_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign saturated_o = sat_q;
  assign last_o      = last_q;

  `CMA_ASSERT(a_slot_free, clk_i, rst_ni, !(mop3_q.vld && mop3_q.fin && out_valid_q),
              "result finished while the output register was full")
  `CMA_ASSERT(a_no_issue_held, clk_i, rst_ni, !(out_valid_q && mop1_q.vld),
              "operation issued while a result was waiting")

endmodule

>>> tb/tb_complex_matrix_arith_3x3.sv
// ----------------------------------------------------------------------------
// tb_complex_matrix_arith_3x3
// Self-checking testbench for the 3x3 complex matrix unit. Sets of nine items
// load A and B, and the ninth item selects the operation. An in-bench model
// keeps its own copy of both matrices and the load position, and queues the
// results each set should produce. A checker compares every returned item
// with the oldest queued one. Directed sets cover identity and saturating
// products, add and subtract at the limits, scaling, trace and a reserved
// operation. Random sets follow, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_matrix_arith_3x3;
  import cma_pkg::*;

  localparam int unsigned FRAC         = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_SETS  = 45;
  localparam logic [2:0]  FUNC_RESERVED = 3'd7;

  typedef logic signed [71:0]        wide_t;
  typedef logic signed [FIELD_W-1:0] word_t;

  typedef struct packed {
    word_t re;
    word_t im;
  } cplx_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    word_t      re;
    word_t      im;
    logic       sat;
    logic       last;
  } result_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t UNIT     = 32'sh0001_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  func_i;
  word_t       a_re_i;
  word_t       a_im_i;
  word_t       b_re_i;
  word_t       b_im_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  row_o;
  logic [1:0]  col_o;
  word_t       out_re_o;
  word_t       out_im_o;
  logic        saturated_o;
  logic        last_o;

  cplx_t       a_mat [ELEMS];
  cplx_t       b_mat [ELEMS];
  cplx_t       next_a [ELEMS];
  cplx_t       next_b [ELEMS];
  int unsigned load_pos;
  result_t     pending_results [$];
  result_t     head;
  int unsigned err_count;
  int unsigned cycle_count;
  bit          no_idle;

  complex_matrix_arith_3x3 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .a_re_i      (a_re_i),
    .a_im_i      (a_im_i),
    .b_re_i      (b_re_i),
    .b_im_i      (b_im_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_o       (row_o),
    .col_o       (col_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .saturated_o (saturated_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic wide_t wmul(word_t x, word_t y);
    return wide_t'(x) * wide_t'(y);
  endfunction

  function automatic word_t clip(input wide_t v, inout logic flag);
    if (v > wide_t'(WORD_MAX)) begin
      flag = 1'b1;
      return WORD_MAX;
    end
    if (v < wide_t'(WORD_MIN)) begin
      flag = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v);
  endfunction

  function automatic void push_result(int k, int n, wide_t re, wide_t im);
    result_t r;
    logic    flag;
    flag   = 1'b0;
    r.re   = clip(re, flag);
    r.im   = clip(im, flag);
    r.sat  = flag;
    r.row  = 2'(k / 3);
    r.col  = 2'(k % 3);
    r.last = (k == n - 1);
    pending_results.push_back(r);
  endfunction

  // Stores one accepted item and, on the ninth, queues what the operation yields.
  function automatic void absorb_item(logic [2:0] f, cplx_t a, cplx_t b);
    int    k;
    int    j;
    wide_t re;
    wide_t im;
    cplx_t x;
    cplx_t y;
    a_mat[load_pos] = a;
    b_mat[load_pos] = b;
    load_pos++;
    if (load_pos < ELEMS) return;
    load_pos = 0;
    case (f)
      FUNC_MUL: begin
        for (k = 0; k < 9; k++) begin
          re = '0;
          im = '0;
          for (j = 0; j < 3; j++) begin
            x  = a_mat[(k / 3) * 3 + j];
            y  = b_mat[j * 3 + k % 3];
            re += wmul(x.re, y.re) - wmul(x.im, y.im);
            im += wmul(x.re, y.im) + wmul(x.im, y.re);
          end
          push_result(k, 9, re >>> FRAC, im >>> FRAC);
        end
      end
      FUNC_ADD, FUNC_SUB: begin
        for (k = 0; k < 9; k++) begin
          x = a_mat[k];
          y = b_mat[k];
          if (f == FUNC_SUB) begin
            re = wide_t'(x.re) - wide_t'(y.re);
            im = wide_t'(x.im) - wide_t'(y.im);
          end else begin
            re = wide_t'(x.re) + wide_t'(y.re);
            im = wide_t'(x.im) + wide_t'(y.im);
          end
          push_result(k, 9, re, im);
        end
      end
      FUNC_SCALE: begin
        x = a_mat[0];
        for (k = 0; k < 9; k++) begin
          y  = b_mat[k];
          re = wmul(x.re, y.re) - wmul(x.im, y.im);
          im = wmul(x.re, y.im) + wmul(x.im, y.re);
          push_result(k, 9, re >>> FRAC, im >>> FRAC);
        end
      end
      FUNC_TRACE: begin
        re = wide_t'(a_mat[0].re) + wide_t'(a_mat[4].re) + wide_t'(a_mat[8].re);
        im = wide_t'(a_mat[0].im) + wide_t'(a_mat[4].im) + wide_t'(a_mat[8].im);
        push_result(0, 1, re, im);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MAX;
        1:       return WORD_MIN;
        2:       return '0;
        default: return -1;
      endcase
    end
    if (pick < 5) return word_t'($urandom);
    return word_t'($urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
  endfunction

  task automatic send_item(logic [2:0] f, cplx_t a, cplx_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    a_re_i     <= a.re;
    a_im_i     <= a.im;
    b_re_i     <= b.re;
    b_im_i     <= b.im;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_item(f, a, b);
  endtask

  // The func of the first eight items is ignored, so it is random there.
  task automatic send_set(logic [2:0] op);
    int k;
    for (k = 0; k < ELEMS; k++) begin
      send_item((k == ELEMS - 1) ? op : 3'($urandom_range(0, 7)), next_a[k], next_b[k]);
    end
  endtask

  task automatic test_multiply_identity();
    int k;
    for (k = 0; k < ELEMS; k++) begin
      next_a[k] = (k % 4 == 0) ? {UNIT, word_t'(0)} : '0;
      next_b[k] = {rand_word(), rand_word()};
    end
    send_set(FUNC_MUL);
  endtask

  task automatic test_multiply_extremes();
    int k;
    for (k = 0; k < ELEMS; k++) begin
      next_a[k] = (k % 2 == 0) ? {WORD_MAX, WORD_MIN} : {WORD_MIN, WORD_MAX};
      next_b[k] = (k < 4) ? {WORD_MIN, WORD_MIN} : {WORD_MAX, word_t'(0)};
    end
    send_set(FUNC_MUL);
  endtask

  task automatic test_add_subtract_extremes();
    int k;
    for (k = 0; k < ELEMS; k++) begin
      next_a[k] = (k % 2 == 0) ? {WORD_MAX, WORD_MIN} : {WORD_MIN, WORD_MAX};
      next_b[k] = (k % 3 == 0) ? {WORD_MAX, WORD_MAX} : {WORD_MIN, word_t'(-1)};
    end
    send_set(FUNC_ADD);
    send_set(FUNC_SUB);
  endtask

  task automatic test_scale_by_first();
    int k;
    for (k = 0; k < ELEMS; k++) begin
      next_a[k] = {rand_word(), rand_word()};
      next_b[k] = {rand_word(), rand_word()};
    end
    next_a[0] = {word_t'(32'sh0001_8000), word_t'(-32'sh0000_4000)};
    send_set(FUNC_SCALE);
  endtask

  task automatic test_trace_extremes();
    int k;
    for (k = 0; k < ELEMS; k++) begin
      next_a[k] = (k % 4 == 0) ? {WORD_MAX, WORD_MIN} : {rand_word(), rand_word()};
      next_b[k] = {rand_word(), rand_word()};
    end
    send_set(FUNC_TRACE);
  endtask

  task automatic test_reserved_func();
    int k;
    for (k = 0; k < ELEMS; k++) begin
      next_a[k] = {rand_word(), rand_word()};
      next_b[k] = {rand_word(), rand_word()};
    end
    send_set(FUNC_RESERVED);
  endtask

  // Mostly valid operations; about one set in seven ends on a reserved func.
  task automatic test_random_sets();
    int          s;
    int          k;
    logic [2:0]  op;
    for (s = 0; s < RANDOM_SETS; s++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < ELEMS; k++) begin
        next_a[k] = {rand_word(), rand_word()};
        next_b[k] = {rand_word(), rand_word()};
      end
      if ($urandom_range(0, 6) == 0) op = 3'($urandom_range(5, 7));
      else op = 3'($urandom_range(0, 4));
      send_set(op);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = '0;
    a_re_i      = '0;
    a_im_i      = '0;
    b_re_i      = '0;
    b_im_i      = '0;
    load_pos    = 0;
    err_count   = 0;
    no_idle     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_multiply_identity();
    test_multiply_extremes();
    test_add_subtract_extremes();
    test_scale_by_first();
    test_trace_extremes();
    test_reserved_func();
    test_random_sets();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      int unsigned stall;
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected item row %0d col %0d re %0d im %0d sat %b last %b",
                 $time, row_o, col_o, out_re_o, out_im_o, saturated_o, last_o);
      end else begin
        head = pending_results.pop_front();
        if (head.row !== row_o || head.col !== col_o || head.re !== out_re_o ||
            head.im !== out_im_o || head.sat !== saturated_o || head.last !== last_o) begin
          err_count++;
          $display("%0t: mismatch expected row %0d col %0d re %0d im %0d sat %b last %b",
                   $time, head.row, head.col, $signed(head.re), $signed(head.im),
                   head.sat, head.last);
          $display("%0t:          actual   row %0d col %0d re %0d im %0d sat %b last %b",
                   $time, row_o, col_o, out_re_o, out_im_o, saturated_o, last_o);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
